// ===== hdl/deq_pkg.sv =====
// shared types and constants for the double-ended queue engine
package deq_pkg;

	localparam int DEPTH = 1024;
	localparam int ELEM_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = ADDR_W + 1;
	localparam int KIND_W = 3;
	localparam int POS_W = 11;
	localparam int ITEM_W = 32;
	localparam int STAT_W = 2;

	typedef enum logic [KIND_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_BACK   = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_READ       = 3'd4,
		REQ_WRITE      = 3'd5,
		REQ_INSERT     = 3'd6,
		REQ_ERASE      = 3'd7
	} req_kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PLACE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] req_type;
		logic [POS_W-1:0]  position;
		logic [ITEM_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [ITEM_W-1:0] item_out;
		logic [POS_W-1:0]  new_size;
		logic [STAT_W-1:0] status;
	} rsp_t;

endpackage

// ===== hdl/double_ended_queue_engine.sv =====
// double-ended queue engine: circular store, head pointer, count and request sequencer
//
// A request is taken when start is high and busy is low; its one result appears on rsp
// for a single cycle with done high and cannot be held off. The store is a single-port
// memory of DEPTH words that takes one access per cycle, and that port paces every
// request until the next possible accept: insert at position p in a queue of n elements
// moves n-p elements and erase at position p moves n-p-1, each move one read and one
// write of the store. Store entries hold no value until written.
module double_ended_queue_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  deq_pkg::req_t req,
	output logic          done,
	output deq_pkg::rsp_t rsp
);

	deq_pkg::state_t state_q, state_nxt;
	deq_pkg::req_t   req_q;
	deq_pkg::status_t status_q;

	logic [deq_pkg::ADDR_W-1:0] head_q;
	logic [deq_pkg::CNT_W-1:0]  count_q;
	logic [deq_pkg::CNT_W-1:0]  idx_q;
	logic [deq_pkg::ELEM_W-1:0] item_q;
	logic [deq_pkg::ELEM_W-1:0] rd_data_q;

	logic [deq_pkg::ELEM_W-1:0] mem [deq_pkg::DEPTH];

	logic [deq_pkg::ADDR_W-1:0] logical;
	logic [deq_pkg::ADDR_W-1:0] slot;
	logic [deq_pkg::ELEM_W-1:0] wdata;
	logic                       we;
	logic                       re;

	logic [deq_pkg::CNT_W-1:0] pos;
	logic [deq_pkg::CNT_W-1:0] count_dec;
	logic [deq_pkg::CNT_W-1:0] idx_dec;
	logic [deq_pkg::CNT_W-1:0] idx_inc;
	logic [deq_pkg::CNT_W:0]   idx_inc2;
	logic [deq_pkg::CNT_W:0]   pos_inc;
	logic                      is_insert;
	logic                      is_full;
	logic                      pos_bad;
	logic                      more_after;
	logic                      more_first;

	assign pos        = deq_pkg::CNT_W'(req_q.position);
	assign count_dec  = count_q - 1'b1;
	assign idx_dec    = idx_q - 1'b1;
	assign idx_inc    = idx_q + 1'b1;
	assign idx_inc2   = {1'b0, idx_q} + (deq_pkg::CNT_W+1)'(2);
	assign pos_inc    = {1'b0, pos} + 1'b1;
	assign is_insert  = (req_q.req_type == deq_pkg::REQ_INSERT);
	assign is_full    = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
	assign pos_bad    = is_insert ? (pos > count_q) : (pos >= count_q);
	assign more_first = (idx_inc < count_q);
	assign more_after = is_insert ? ({1'b0, idx_q} > pos_inc)
	                              : (idx_inc2 < {1'b0, count_q});

	// shared slot adder: head plus logical index, wrapping at the store depth
	assign slot = head_q + logical;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			deq_pkg::S_IDLE: begin
				if (start) state_nxt = deq_pkg::S_EXEC;
			end
			deq_pkg::S_EXEC: begin
				case (req_q.req_type)
					deq_pkg::REQ_PUSH_BACK, deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_WRITE: begin
						state_nxt = deq_pkg::S_DONE;
					end
					deq_pkg::REQ_POP_BACK, deq_pkg::REQ_POP_FRONT: begin
						state_nxt = (count_q == '0) ? deq_pkg::S_DONE : deq_pkg::S_FETCH;
					end
					deq_pkg::REQ_READ, deq_pkg::REQ_ERASE: begin
						state_nxt = pos_bad ? deq_pkg::S_DONE : deq_pkg::S_FETCH;
					end
					deq_pkg::REQ_INSERT: begin
						if (pos_bad || is_full) state_nxt = deq_pkg::S_DONE;
						else if (count_q > pos) state_nxt = deq_pkg::S_SHIFT_RD;
						else state_nxt = deq_pkg::S_PLACE;
					end
					default: state_nxt = deq_pkg::S_DONE;
				endcase
			end
			deq_pkg::S_FETCH: begin
				if (req_q.req_type == deq_pkg::REQ_ERASE && more_first)
					state_nxt = deq_pkg::S_SHIFT_RD;
				else
					state_nxt = deq_pkg::S_DONE;
			end
			deq_pkg::S_SHIFT_RD: state_nxt = deq_pkg::S_SHIFT_WR;
			deq_pkg::S_SHIFT_WR: begin
				if (more_after) state_nxt = deq_pkg::S_SHIFT_RD;
				else if (is_insert) state_nxt = deq_pkg::S_PLACE;
				else state_nxt = deq_pkg::S_DONE;
			end
			deq_pkg::S_PLACE: state_nxt = deq_pkg::S_DONE;
			deq_pkg::S_DONE:  state_nxt = deq_pkg::S_IDLE;
			default:          state_nxt = deq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		logical = '0;
		we      = 1'b0;
		re      = 1'b0;
		wdata   = req_q.item_value[deq_pkg::ELEM_W-1:0];
		case (state_q)
			deq_pkg::S_EXEC: begin
				case (req_q.req_type)
					deq_pkg::REQ_PUSH_BACK: begin
						logical = count_q[deq_pkg::ADDR_W-1:0];
						we      = !is_full;
					end
					deq_pkg::REQ_PUSH_FRONT: begin
						logical = '1;
						we      = !is_full;
					end
					deq_pkg::REQ_POP_BACK: begin
						logical = count_dec[deq_pkg::ADDR_W-1:0];
						re      = (count_q != '0);
					end
					deq_pkg::REQ_POP_FRONT: begin
						logical = '0;
						re      = (count_q != '0);
					end
					deq_pkg::REQ_READ, deq_pkg::REQ_ERASE: begin
						logical = pos[deq_pkg::ADDR_W-1:0];
						re      = !pos_bad;
					end
					deq_pkg::REQ_WRITE: begin
						logical = pos[deq_pkg::ADDR_W-1:0];
						we      = !pos_bad;
					end
					default: logical = '0;
				endcase
			end
			deq_pkg::S_SHIFT_RD: begin
				logical = is_insert ? idx_dec[deq_pkg::ADDR_W-1:0]
				                    : idx_inc[deq_pkg::ADDR_W-1:0];
				re      = 1'b1;
			end
			deq_pkg::S_SHIFT_WR: begin
				logical = idx_q[deq_pkg::ADDR_W-1:0];
				we      = 1'b1;
				wdata   = rd_data_q;
			end
			deq_pkg::S_PLACE: begin
				logical = pos[deq_pkg::ADDR_W-1:0];
				we      = 1'b1;
			end
			default: logical = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[slot] <= wdata;
		if (re) rd_data_q <= mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= deq_pkg::S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				deq_pkg::S_EXEC: begin
					case (req_q.req_type)
						deq_pkg::REQ_PUSH_BACK: begin
							if (!is_full) count_q <= count_q + 1'b1;
						end
						deq_pkg::REQ_PUSH_FRONT: begin
							if (!is_full) begin
								head_q  <= slot;
								count_q <= count_q + 1'b1;
							end
						end
						deq_pkg::REQ_POP_BACK: begin
							if (count_q != '0) count_q <= count_dec;
						end
						deq_pkg::REQ_POP_FRONT: begin
							if (count_q != '0) begin
								head_q  <= head_q + 1'b1;
								count_q <= count_dec;
							end
						end
						default: count_q <= count_q;
					endcase
				end
				deq_pkg::S_FETCH: begin
					if (req_q.req_type == deq_pkg::REQ_ERASE && !more_first)
						count_q <= count_dec;
				end
				deq_pkg::S_SHIFT_WR: begin
					if (!is_insert && !more_after) count_q <= count_dec;
				end
				deq_pkg::S_PLACE: count_q <= count_q + 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			deq_pkg::S_IDLE: begin
				if (start) req_q <= req;
			end
			deq_pkg::S_EXEC: begin
				item_q   <= '0;
				status_q <= deq_pkg::ST_OK;
				idx_q    <= is_insert ? count_q : pos;
				case (req_q.req_type)
					deq_pkg::REQ_PUSH_BACK, deq_pkg::REQ_PUSH_FRONT: begin
						if (is_full) status_q <= deq_pkg::ST_FULL;
					end
					deq_pkg::REQ_POP_BACK, deq_pkg::REQ_POP_FRONT: begin
						if (count_q == '0) status_q <= deq_pkg::ST_EMPTY;
					end
					deq_pkg::REQ_INSERT: begin
						if (pos_bad) status_q <= deq_pkg::ST_RANGE;
						else if (is_full) status_q <= deq_pkg::ST_FULL;
					end
					default: begin
						if (pos_bad) status_q <= deq_pkg::ST_RANGE;
					end
				endcase
			end
			deq_pkg::S_FETCH: item_q <= rd_data_q;
			deq_pkg::S_SHIFT_WR: idx_q <= is_insert ? idx_dec : idx_inc;
			default: idx_q <= idx_q;
		endcase
	end

	assign busy         = (state_q != deq_pkg::S_IDLE);
	assign done         = (state_q == deq_pkg::S_DONE);
	assign rsp.item_out = deq_pkg::ITEM_W'(item_q);
	assign rsp.new_size = deq_pkg::POS_W'(count_q);
	assign rsp.status   = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
		else $error("element count above depth");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re))
		else $error("store read and written in one cycle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == deq_pkg::ST_FULL |->
			count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH))
		else $error("full status with room left");
`endif

endmodule

// ===== tb/tb_double_ended_queue_engine.sv =====
// self-checking testbench for the double-ended queue engine
`timescale 1ns / 1ps

module tb_double_ended_queue_engine;

	import deq_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT = 40;
	localparam int RANDOM_PER_PHASE = 260;
	localparam int SOFT_CAP = 48;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		logic [ITEM_W-1:0] value;
		logic              has_exp;
		rsp_t              exp_rsp;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam stim_row_t DIRECTED_TBL [DIRECTED_ROWS] = '{
		'{REQ_POP_BACK,   11'd0,    32'h0000_0000, 1'b1, '{32'h0, 11'd0, ST_EMPTY}},
		'{REQ_POP_FRONT,  11'd0,    32'h0000_0000, 1'b1, '{32'h0, 11'd0, ST_EMPTY}},
		'{REQ_READ,       11'd0,    32'h0000_0000, 1'b1, '{32'h0, 11'd0, ST_RANGE}},
		'{REQ_WRITE,      11'd0,    32'hDEAD_BEEF, 1'b1, '{32'h0, 11'd0, ST_RANGE}},
		'{REQ_ERASE,      11'd0,    32'h0000_0000, 1'b1, '{32'h0, 11'd0, ST_RANGE}},
		'{REQ_INSERT,     11'd1,    32'h1111_1111, 1'b1, '{32'h0, 11'd0, ST_RANGE}},
		'{REQ_INSERT,     11'd2047, 32'h2222_2222, 1'b1, '{32'h0, 11'd0, ST_RANGE}},
		'{REQ_INSERT,     11'd0,    32'hFFFF_FFFF, 1'b1, '{32'h0, 11'd1, ST_OK}},
		'{REQ_PUSH_BACK,  11'd0,    32'h0000_0000, 1'b1, '{32'h0, 11'd2, ST_OK}},
		'{REQ_PUSH_FRONT, 11'd0,    32'h8000_0001, 1'b1, '{32'h0, 11'd3, ST_OK}},
		'{REQ_READ,       11'd0,    32'h0000_0000, 1'b1, '{32'h8000_0001, 11'd3, ST_OK}},
		'{REQ_READ,       11'd2,    32'h0000_0000, 1'b1, '{32'h0, 11'd3, ST_OK}},
		'{REQ_READ,       11'd3,    32'h0000_0000, 1'b1, '{32'h0, 11'd3, ST_RANGE}},
		'{REQ_WRITE,      11'd1,    32'hA5A5_5A5A, 1'b0, '0},
		'{REQ_INSERT,     11'd3,    32'h1234_5678, 1'b0, '0},
		'{REQ_INSERT,     11'd1,    32'h0000_0000, 1'b0, '0},
		'{REQ_ERASE,      11'd0,    32'h0000_0000, 1'b0, '0},
		'{REQ_ERASE,      11'd3,    32'h0000_0000, 1'b0, '0},
		'{REQ_READ,       11'd1024, 32'h0000_0000, 1'b1, '{32'h0, 11'd3, ST_RANGE}},
		'{REQ_POP_BACK,   11'd0,    32'h0000_0000, 1'b0, '0},
		'{REQ_POP_FRONT,  11'd0,    32'h0000_0000, 1'b0, '0},
		'{REQ_POP_FRONT,  11'd0,    32'h0000_0000, 1'b0, '0},
		'{REQ_POP_FRONT,  11'd0,    32'h0000_0000, 1'b1, '{32'h0, 11'd0, ST_EMPTY}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;

	logic [ITEM_W-1:0] shadow_store [DEPTH];
	logic [ADDR_W-1:0] front = '0;
	int fill = 0;

	rsp_t pending_rsp [$];
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int gap_pct = 0;

	double_ended_queue_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] slot_at(input int idx);
		return front + ADDR_W'(idx);
	endfunction

	function automatic rsp_t deque_model(input req_t r);
		rsp_t o;
		int n;
		int i;
		o = '0;
		o.status = ST_OK;
		n = int'(r.position);
		case (r.req_type)
			REQ_PUSH_BACK: begin
				if (fill >= DEPTH) o.status = ST_FULL;
				else begin
					shadow_store[slot_at(fill)] = r.item_value;
					fill++;
				end
			end
			REQ_PUSH_FRONT: begin
				if (fill >= DEPTH) o.status = ST_FULL;
				else begin
					front = front - 1'b1;
					shadow_store[front] = r.item_value;
					fill++;
				end
			end
			REQ_POP_BACK: begin
				if (fill == 0) o.status = ST_EMPTY;
				else begin
					o.item_out = shadow_store[slot_at(fill - 1)];
					fill--;
				end
			end
			REQ_POP_FRONT: begin
				if (fill == 0) o.status = ST_EMPTY;
				else begin
					o.item_out = shadow_store[front];
					front = front + 1'b1;
					fill--;
				end
			end
			REQ_READ: begin
				if (n >= fill) o.status = ST_RANGE;
				else o.item_out = shadow_store[slot_at(n)];
			end
			REQ_WRITE: begin
				if (n >= fill) o.status = ST_RANGE;
				else shadow_store[slot_at(n)] = r.item_value;
			end
			REQ_INSERT: begin
				if (n > fill) o.status = ST_RANGE;
				else if (fill >= DEPTH) o.status = ST_FULL;
				else begin
					for (i = fill; i > n; i--)
						shadow_store[slot_at(i)] = shadow_store[slot_at(i - 1)];
					shadow_store[slot_at(n)] = r.item_value;
					fill++;
				end
			end
			default: begin
				if (n >= fill) o.status = ST_RANGE;
				else begin
					o.item_out = shadow_store[slot_at(n)];
					for (i = n; i + 1 < fill; i++)
						shadow_store[slot_at(i)] = shadow_store[slot_at(i + 1)];
					fill--;
				end
			end
		endcase
		o.new_size = POS_W'(fill);
		return o;
	endfunction

	task automatic issue(input req_t r, input logic has_exp, input rsp_t exp_rsp);
		rsp_t predicted;
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = deque_model(r);
		pending_rsp.insert(pending_rsp.size(), has_exp ? exp_rsp : predicted);
	endtask

	function automatic req_t random_request();
		req_t r;
		int roll;
		r.req_type = KIND_W'($urandom_range(0, 7));
		if (fill > SOFT_CAP && $urandom_range(0, 1) &&
				r.req_type inside {REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT})
			r.req_type = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_ERASE;
		if (fill < 3 && $urandom_range(0, 1) &&
				r.req_type inside {REQ_POP_BACK, REQ_POP_FRONT, REQ_ERASE})
			r.req_type = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_INSERT;
		if ($urandom_range(0, 9) < 8) r.position = POS_W'($urandom_range(0, fill));
		else r.position = POS_W'($urandom_range(0, 2047));
		roll = $urandom_range(0, 9);
		if (roll == 0) r.item_value = '0;
		else if (roll == 1) r.item_value = '1;
		else r.item_value = $urandom;
		return r;
	endfunction

	// result check
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: unexpected result item_out %h new_size %0d status %0d",
						$realtime, rsp.item_out, rsp.new_size, rsp.status);
			end else begin
				want = pending_rsp[0];
				pending_rsp.delete(0);
				if (rsp.item_out !== want.item_out || rsp.new_size !== want.new_size ||
						rsp.status !== want.status) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: mismatch item_out %h/%h new_size %0d/%0d status %0d/%0d",
							$realtime, want.item_out, rsp.item_out, want.new_size,
							rsp.new_size, want.status, rsp.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_double_ended_queue_engine NOT OK");
			$finish;
		end
	end

	initial begin
		int k;
		int p;
		req_t r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (k = 0; k < DIRECTED_ROWS; k++) begin
			r.req_type = DIRECTED_TBL[k].kind;
			r.position = DIRECTED_TBL[k].pos;
			r.item_value = DIRECTED_TBL[k].value;
			issue(r, DIRECTED_TBL[k].has_exp, DIRECTED_TBL[k].exp_rsp);
		end

		// random phases with different request gaps
		for (p = 0; p < 3; p++) begin
			gap_pct = (p == 0) ? 0 : (p == 1) ? 66 : 13;
			for (k = 0; k < RANDOM_PER_PHASE; k++)
				issue(random_request(), 1'b0, '0);
		end

		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_cnt == 0 && pending_rsp.size() == 0)
			$display("tb_double_ended_queue_engine OK");
		else
			$display("tb_double_ended_queue_engine NOT OK");
		$finish;
	end

endmodule

// ===== double_ended_queue_engine.f =====
hdl/deq_pkg.sv
hdl/double_ended_queue_engine.sv
tb/tb_double_ended_queue_engine.sv
